FILE: rtl/igst_pkg.sv
// Package: pipeline word type, stage map and per-stage arithmetic of the inverse Gaussian sampler.
`default_nettype none
package igst_pkg;

    localparam int unsigned SqrtSteps  = 32;
    localparam int unsigned FracSteps  = 32;
    localparam int unsigned DivSteps   = 32;

    localparam int unsigned StgSquare  = 1;
    localparam int unsigned StgMulA    = 2;
    localparam int unsigned StgAddB    = 3;
    localparam int unsigned StgSqrt0   = 4;
    localparam int unsigned StgFracIn  = StgSqrt0 + SqrtSteps;
    localparam int unsigned StgFrac0   = StgFracIn + 1;
    localparam int unsigned StgMulX    = StgFrac0 + FracSteps;
    localparam int unsigned StgClampX  = StgMulX + 1;
    localparam int unsigned StgMulT    = StgClampX + 1;
    localparam int unsigned StgTest    = StgMulT + 1;
    localparam int unsigned StgDiv0    = StgTest + 1;
    localparam int unsigned StgResult  = StgDiv0 + DivSteps;
    localparam int unsigned NumStages  = StgResult + 1;

    localparam logic [31:0] SampleMax  = 32'hFFFF_FFFF;

    typedef struct packed {
        logic        inv;
        logic [31:0] mu;
        logic [31:0] lam;
        logic [15:0] u;
        logic [15:0] mag;
        logic [31:0] y;
        logic [63:0] a;
        logic        azero;
        logic [63:0] va;
        logic [63:0] ra;
        logic [63:0] vb;
        logic [63:0] rb;
        logic [32:0] den;
        logic [33:0] rem;
        logic [31:0] q;
        logic [31:0] x;
        logic [48:0] lhs;
        logic [63:0] mu2;
        logic        acc;
        logic        sat;
        logic [32:0] drem;
        logic [31:0] dlo;
        logic [31:0] res;
    } t_pipe;

    // One register stage worth of work; k is the stage number, fixed per instance.
    function automatic t_pipe igst_step(input int unsigned k, input t_pipe p);
        t_pipe       n;
        logic [63:0] sq_bit;
        logic [63:0] ta;
        logic [63:0] tb;
        logic [33:0] r2;
        logic [32:0] t2;
        logic [63:0] prod;
        logic [32:0] sum;
        n      = p;
        sq_bit = 64'd1 << (62 - 2 * (k - StgSqrt0));
        ta     = p.ra + sq_bit;
        tb     = p.rb + sq_bit;
        r2     = {p.rem[32:0], 1'b0};
        t2     = {p.drem[31:0], p.dlo[31]};
        prod   = 64'(p.mu) * 64'(p.q);
        sum    = 33'(p.mu) + 33'(p.x);
        if (k == StgSquare) begin
            n.y = 32'(p.mag) * 32'(p.mag);
        end else if (k == StgMulA) begin
            n.a = 64'(p.mu) * 64'(p.y);
        end else if (k == StgAddB) begin
            n.azero = (p.a == 64'd0);
            n.va    = p.a;
            n.ra    = 64'd0;
            n.vb    = p.a + {6'd0, p.lam, 26'd0};
            n.rb    = 64'd0;
        end else if (k >= StgSqrt0 && k < StgFracIn) begin
            if (p.va >= ta) begin
                n.va = p.va - ta;
                n.ra = (p.ra >> 1) + sq_bit;
            end else begin
                n.ra = p.ra >> 1;
            end
            if (p.vb >= tb) begin
                n.vb = p.vb - tb;
                n.rb = (p.rb >> 1) + sq_bit;
            end else begin
                n.rb = p.rb >> 1;
            end
        end else if (k == StgFracIn) begin
            n.rem = {2'd0, p.rb[31:0] - p.ra[31:0]};
            n.den = {1'b0, p.rb[31:0]} + {1'b0, p.ra[31:0]};
            n.q   = 32'd0;
        end else if (k >= StgFrac0 && k < StgMulX) begin
            if (r2 >= {1'b0, p.den}) begin
                n.rem = r2 - {1'b0, p.den};
                n.q   = {p.q[30:0], 1'b1};
            end else begin
                n.rem = r2;
                n.q   = {p.q[30:0], 1'b0};
            end
        end else if (k == StgMulX) begin
            n.x = prod[63:32];
        end else if (k == StgClampX) begin
            if (p.azero) begin
                n.x = p.mu;
            end else if (p.x == 32'd0) begin
                n.x = 32'd1;
            end
        end else if (k == StgMulT) begin
            n.lhs = 49'(p.u) * 49'(sum);
            n.mu2 = 64'(p.mu) * 64'(p.mu);
        end else if (k == StgTest) begin
            n.acc  = (p.lhs <= {1'b0, p.mu, 16'd0});
            n.sat  = (p.mu2[63:32] >= p.x);
            n.drem = {1'b0, p.mu2[63:32]};
            n.dlo  = p.mu2[31:0];
        end else if (k >= StgDiv0 && k < StgResult) begin
            // Remainder stays below x, so the shifted value fits 33 bits.
            if (t2 >= {1'b0, p.x}) begin
                n.drem = t2 - {1'b0, p.x};
                n.dlo  = {p.dlo[30:0], 1'b1};
            end else begin
                n.drem = t2;
                n.dlo  = {p.dlo[30:0], 1'b0};
            end
        end else if (k == StgResult) begin
            if (p.inv) begin
                n.res = 32'd0;
            end else if (p.acc) begin
                n.res = p.x;
            end else if (p.sat) begin
                n.res = SampleMax;
            end else begin
                n.res = p.dlo;
            end
        end
        return n;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/igst_in_if.sv
// Interface: input channel carrying the distribution parameters and the random draws.
`default_nettype none
interface igst_in_if;
    logic               valid;
    logic               ready;
    logic [31:0]        mean_value;
    logic [31:0]        shape_value;
    logic [15:0]        uniform_draw;
    logic signed [15:0] normal_draw;
    modport source (output valid, mean_value, shape_value, uniform_draw, normal_draw,
                    input ready);
    modport sink (input valid, mean_value, shape_value, uniform_draw, normal_draw,
                  output ready);
endinterface
`default_nettype wire

FILE: rtl/igst_out_if.sv
// Interface: output channel carrying the sample and the invalid flag.
`default_nettype none
interface igst_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] sample_value;
    logic        invalid;
    modport source (output valid, sample_value, invalid, input ready);
    modport sink (input valid, sample_value, invalid, output ready);
endinterface
`default_nettype wire

FILE: rtl/igst_stage.sv
// Module: one register stage of the sampler pipeline with its valid bit.
`default_nettype none
module igst_stage #(
    parameter int unsigned STAGE = 1
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire logic           i_vld,
    input  wire igst_pkg::t_pipe i_data,
    output logic                o_vld,
    output igst_pkg::t_pipe     o_data
);
    logic            r_vld;
    igst_pkg::t_pipe r_data;
    igst_pkg::t_pipe n_data;

    always_comb begin
        n_data = igst_pkg::igst_step(STAGE, i_data);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_vld  = r_vld;
    assign o_data = r_data;
endmodule
`default_nettype wire

FILE: rtl/inverse_gaussian_sample_transform_top.sv
// Top level: fully pipelined inverse Gaussian sampler (Michael-Schucany-Haas transform).
// The block accepts one word per clock while the output is not stalled and returns one
// result word per input word, in order, from the last of its igst_stage registers. The
// pipeline depth is set by the bit-per-stage square roots (32 stages), the
// bit-per-stage fraction divide (32 stages) and the bit-per-stage reflection divide
// (32 stages). The whole pipeline holds when the output word is waiting and not taken,
// so ready on the input follows the output side.
`default_nettype none
module inverse_gaussian_sample_transform_top (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    igst_in_if.sink      i_in,
    igst_out_if.source   o_out
);
    localparam int unsigned NStg = igst_pkg::NumStages;

    logic            w_en;
    logic            w_vld  [NStg];
    igst_pkg::t_pipe w_data [NStg];
    logic            r_vld0;
    igst_pkg::t_pipe r_data0;
    igst_pkg::t_pipe n_data0;

    assign w_en       = !w_vld[NStg-1] || o_out.ready;
    assign i_in.ready = w_en;

    always_comb begin
        n_data0     = '0;
        n_data0.inv = (i_in.mean_value == 32'd0) || (i_in.shape_value == 32'd0);
        n_data0.mu  = i_in.mean_value;
        n_data0.lam = i_in.shape_value;
        n_data0.u   = i_in.uniform_draw;
        n_data0.mag = i_in.normal_draw[15] ? 16'(-i_in.normal_draw)
                                           : i_in.normal_draw;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
        end else if (w_en) begin
            r_vld0 <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_data0 <= n_data0;
        end
    end

    assign w_vld[0]  = r_vld0;
    assign w_data[0] = r_data0;

    for (genvar g = 1; g < NStg; g++) begin : g_stg
        igst_stage #(.STAGE(g)) u_stage (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_en),
            .i_vld  (w_vld[g-1]),
            .i_data (w_data[g-1]),
            .o_vld  (w_vld[g]),
            .o_data (w_data[g])
        );
    end

    assign o_out.valid        = w_vld[NStg-1];
    assign o_out.sample_value = w_data[NStg-1].res;
    assign o_out.invalid      = w_data[NStg-1].inv;
endmodule
`default_nettype wire

FILE: rtl/igst_checker.sv
// Checker: port-level assertions for the sampler top level, with its bind.
`default_nettype none
module igst_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [31:0] i_sample,
    input wire logic        i_invalid
);
    // Flow control: input side moves exactly when the output is free or drained.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready == (!i_out_valid || i_out_ready))
        else $error("input ready does not follow output side");

    // An invalid result always carries a zero sample.
    a_inv_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_invalid) |-> (i_sample == 32'd0))
        else $error("invalid word with nonzero sample");

    // A stalled word holds its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_sample)
                                           && $stable(i_invalid)))
        else $error("stalled output word changed");

    // No word right after reset.
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");
endmodule

bind inverse_gaussian_sample_transform_top igst_checker u_igst_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_ready (i_in.ready),
    .i_out_valid(o_out.valid),
    .i_out_ready(o_out.ready),
    .i_sample   (o_out.sample_value),
    .i_invalid  (o_out.invalid)
);
`default_nettype wire
